### rtl/npi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npi_pkg
// Shared constants, types and helpers of the noncoherent pulse integrator.
// ----------------------------------------------------------------------------
package npi_pkg;

	localparam int GATES       = 1024;
	localparam int MAX_PULSES  = 16;
	localparam int SAMPLE_BITS = 16;

	localparam int SMP_W      = 16;
	localparam int VAL_W      = 17;
	localparam int NP_W       = 5;
	localparam int GATE_W     = $clog2(GATES);
	localparam int POS_W      = GATE_W + 1;
	localparam int SLOT_W     = $clog2(MAX_PULSES);
	localparam int N_W        = $clog2(MAX_PULSES + 1);
	localparam int RING_AW    = SLOT_W + GATE_W;
	localparam int RING_DEPTH = 2 ** RING_AW;
	localparam int SUM_W      = 38;
	localparam int RING_W     = 32;
	localparam int V_W        = RING_W + 1;
	localparam int MAG_W      = 36;
	localparam int DIV_STEP   = 6;
	localparam int DIV_STAGES = MAG_W / DIV_STEP;
	localparam int ROOT_W     = 16;
	localparam int X_W        = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 4;
	localparam int SQ_STEP    = 4;
	localparam int SQ_STAGES  = ROOT_W / SQ_STEP;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int SEXT_SH    = SMP_W - SAMPLE_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED    = 2'd0,
		REG_NUM_PULSES = 2'd1,
		REG_IQ_MODE    = 2'd2
	} cfg_reg_t;

	// Control that travels with every request through the pipeline.
	typedef struct packed {
		logic              vld;
		logic              res;
		logic              byp;
		logic              last;
		logic              iq;
		logic [VAL_W-1:0]  byp_val;
		logic [SMP_W-1:0]  byp_q;
	} npi_tag_t;

	function automatic logic signed [SMP_W-1:0] sext_sample(input logic [SMP_W-1:0] raw);
		logic [SMP_W-1:0] t;
		t = raw << SEXT_SH;
		return $signed(t) >>> SEXT_SH;
	endfunction

	function automatic logic [N_W-1:0] window_len(input logic [NP_W-1:0] np);
		logic [N_W-1:0] n;
		if (np == '0) begin
			n = N_W'(1);
		end else if (int'(np) > MAX_PULSES) begin
			n = N_W'(MAX_PULSES);
		end else begin
			n = N_W'(np);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

### rtl/npi_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npi_ifs
// Sample, result and register-write channels of the pulse integrator.
// ----------------------------------------------------------------------------
interface npi_in_if;
	import npi_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample_i;
	logic signed [SMP_W-1:0] sample_q;
	logic                    pulse_end;
	modport source(output valid, sample_i, sample_q, pulse_end, input ready);
	modport sink(input valid, sample_i, sample_q, pulse_end, output ready);
endinterface

interface npi_out_if;
	import npi_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic signed [SMP_W-1:0] bypass_q;
	logic                    last_gate;
	modport source(output valid, value, bypass_q, last_gate, input ready);
	modport sink(input valid, value, bypass_q, last_gate, output ready);
endinterface

interface npi_cfg_if;
	import npi_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/noncoherent_pulse_integrator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// noncoherent_pulse_integrator
// Sliding-window noncoherent integration of radar range gates over N pulses.
// ----------------------------------------------------------------------------
// Samples enter on din, one range gate per request in gate order, with
// pulse_end on the last gate of each pulse. Results leave on dout; cfg writes
// the enabled, num_pulses and iq_mode registers and is always ready.
// One request is taken every cycle while no clearing pass or dout stall holds
// the flow. The path from din to dout holds 17 registers: three update the
// per-gate sum and history ring, eight divide by the window length, five take
// the root, and the output register holds it.
// Requests that give no result (window still filling, gates past the end)
// travel as bubbles and keep their place.
// After reset, and after each write of num_pulses or iq_mode, a clearing pass
// sweeps the history ring, all 16384 entries, one entry a cycle; din.ready stays
// low until it ends. Register writes are expected only when the block is idle.
// When dout stalls, the whole pipeline holds and din.ready drops with it.
// ----------------------------------------------------------------------------
module noncoherent_pulse_integrator import npi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	npi_in_if.sink      din,
	npi_out_if.source   dout,
	npi_cfg_if.sink     cfg
);

	logic              enabled_q;
	logic [NP_W-1:0]   np_q;
	logic              iq_q;
	logic [N_W-1:0]    pulses_q;
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [SMP_W-1:0] bypass_q_q;
	logic                    last_q;

	logic                    en, acc, cfg_wr, clr_start, clearing;
	logic [N_W-1:0]          n_w;
	logic                    byp, in_range, upd;
	logic signed [SMP_W-1:0] si, sq;
	npi_tag_t                tag_in, tag_acc, tag_div, tag_sq;
	logic signed [SUM_W-1:0] sum;
	logic [MAG_W-1:0]        q;
	logic                    neg;
	logic [ROOT_W-1:0]       root;
	logic [REM_W-1:0]        rem;
	logic [VAL_W-1:0]        raw, rnd, res_val;

	assign en        = !out_valid_q || dout.ready;
	assign din.ready = en && !clearing;
	assign acc       = din.valid && din.ready;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign clr_start = cfg_wr && (cfg.index == REG_NUM_PULSES || cfg.index == REG_IQ_MODE);

	assign n_w      = window_len(np_q);
	assign byp      = !enabled_q || n_w == N_W'(1);
	assign in_range = pos_q < POS_W'(GATES);
	assign upd      = acc && !byp && in_range;
	assign si       = sext_sample(din.sample_i);
	assign sq       = sext_sample(din.sample_q);

	always_comb begin
		tag_in.vld     = acc;
		tag_in.res     = byp || (in_range && ({1'b0, pulses_q} + 1'b1) >= {1'b0, n_w});
		tag_in.byp     = byp;
		tag_in.last    = din.pulse_end;
		tag_in.iq      = iq_q;
		tag_in.byp_val = VAL_W'(si);
		tag_in.byp_q   = iq_q ? sq : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			np_q      <= NP_W'(4);
			iq_q      <= 1'b0;
			pulses_q  <= '0;
			slot_q    <= '0;
			pos_q     <= '0;
		end else if (cfg_wr) begin
			if (cfg.index == REG_ENABLED) begin
				enabled_q <= cfg.data[0];
			end
			if (cfg.index == REG_NUM_PULSES) begin
				np_q <= cfg.data;
			end
			if (cfg.index == REG_IQ_MODE) begin
				iq_q <= cfg.data[0];
			end
			if (clr_start) begin
				pulses_q <= '0;
				slot_q   <= '0;
				pos_q    <= '0;
			end
		end else if (acc) begin
			if (din.pulse_end) begin
				pos_q <= '0;
				if (!byp) begin
					slot_q <= ({1'b0, slot_q} + 1'b1 == n_w) ? '0 : slot_q + 1'b1;
					if (pulses_q < n_w) begin
						pulses_q <= pulses_q + 1'b1;
					end
				end
			end else if (in_range) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	npi_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.clr_start (clr_start),
		.upd       (upd),
		.gate      (pos_q[GATE_W-1:0]),
		.slot      (slot_q),
		.si        (si),
		.sq        (sq),
		.tag       (tag_in),
		.clearing  (clearing),
		.sum       (sum),
		.tag_o     (tag_acc)
	);

	npi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.sum    (sum),
		.n      (n_w),
		.tag    (tag_acc),
		.q      (q),
		.neg    (neg),
		.tag_o  (tag_div)
	);

	npi_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.q      (q),
		.neg    (neg),
		.tag    (tag_div),
		.root   (root),
		.rem    (rem),
		.raw    (raw),
		.tag_o  (tag_sq)
	);

	// Round the root up when the remainder exceeds it.
	assign rnd     = {1'b0, root} + VAL_W'(rem > REM_W'(root));
	assign res_val = tag_sq.byp ? tag_sq.byp_val : (tag_sq.iq ? rnd : raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tag_sq.vld && tag_sq.res;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q    <= $signed(res_val);
			bypass_q_q <= tag_sq.byp ? $signed(tag_sq.byp_q) : '0;
			last_q     <= tag_sq.last;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.value     = value_q;
	assign dout.bypass_q  = bypass_q_q;
	assign dout.last_gate = last_q;

`ifndef SYNTH
	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < n_w)
		else $error("ring slot outside the window");
	a_pulses_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pulses_q <= n_w)
		else $error("pulse count above window length");
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !acc)
		else $error("request accepted during clearing pass");
`endif

endmodule
`default_nettype wire

### rtl/npi_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npi_accum
// Per-gate window sums and history ring, with forwarding and clearing pass.
// ----------------------------------------------------------------------------
module npi_accum import npi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    clr_start,
	input  logic                    upd,
	input  logic [GATE_W-1:0]       gate,
	input  logic [SLOT_W-1:0]       slot,
	input  logic signed [SMP_W-1:0] si,
	input  logic signed [SMP_W-1:0] sq,
	input  npi_tag_t                tag,
	output logic                    clearing,
	output logic signed [SUM_W-1:0] sum,
	output npi_tag_t                tag_o
);

	logic [SUM_W-1:0]  sum_mem  [GATES];
	logic [RING_W-1:0] ring_mem [RING_DEPTH];

	logic               clearing_q;
	logic [RING_AW-1:0] clr_cnt_q;

	npi_tag_t                tag_s1, tag_s2, tag_s3;
	logic                    upd_s1, upd_s2, upd_s3, upd_s4;
	logic [GATE_W-1:0]       gate_s1, gate_s2, gate_s3, gate_s4;
	logic [SLOT_W-1:0]       slot_s1, slot_s2, slot_s3, slot_s4;
	logic signed [SMP_W-1:0] si_s1, sq_s1, si_s2;
	logic [SUM_W-1:0]        rsum_s1, rsum_s2;
	logic [RING_W-1:0]       rring_s1, rring_s2;
	logic [RING_W-1:0]       pi_s2, pq_s2;
	logic signed [SUM_W-1:0] sum_s3, sum_s4;
	logic signed [V_W-1:0]   v_s3, v_s4;

	logic signed [V_W-1:0]   v, ring_f;
	logic signed [SUM_W-1:0] sum_f, new_sum;
	logic [RING_W-1:0]       sq_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_start) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == RING_AW'(RING_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Control of each stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			upd_s1 <= 1'b0;
			upd_s2 <= 1'b0;
			upd_s3 <= 1'b0;
			upd_s4 <= 1'b0;
		end else if (clearing_q) begin
			upd_s1 <= 1'b0;
			upd_s2 <= 1'b0;
			upd_s3 <= 1'b0;
			upd_s4 <= 1'b0;
			if (en) begin
				tag_s1 <= tag;
				tag_s2 <= tag_s1;
				tag_s3 <= tag_s2;
			end
		end else if (en) begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			upd_s1 <= upd;
			upd_s2 <= upd_s1;
			upd_s3 <= upd_s2;
			upd_s4 <= upd_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gate_s1  <= gate;
			slot_s1  <= slot;
			si_s1    <= si;
			sq_s1    <= sq;
			rsum_s1  <= sum_mem[gate];
			rring_s1 <= ring_mem[{slot, gate}];

			gate_s2  <= gate_s1;
			slot_s2  <= slot_s1;
			si_s2    <= si_s1;
			rsum_s2  <= rsum_s1;
			rring_s2 <= rring_s1;
			pi_s2    <= si_s1 * si_s1;
			pq_s2    <= sq_s1 * sq_s1;

			gate_s3  <= gate_s2;
			slot_s3  <= slot_s2;
			sum_s3   <= new_sum;
			v_s3     <= v;

			gate_s4  <= gate_s3;
			slot_s4  <= slot_s3;
			sum_s4   <= sum_s3;
			v_s4     <= v_s3;
		end
	end

	// The two requests ahead have not reached memory yet when this one read it.
	always_comb begin
		sq_sum = pi_s2 + pq_s2;
		v = tag_s2.iq ? $signed({1'b0, sq_sum}) : V_W'(si_s2);
		if (upd_s3 && gate_s3 == gate_s2) begin
			sum_f = sum_s3;
		end else if (upd_s4 && gate_s4 == gate_s2) begin
			sum_f = sum_s4;
		end else begin
			sum_f = $signed(rsum_s2);
		end
		if (upd_s3 && gate_s3 == gate_s2 && slot_s3 == slot_s2) begin
			ring_f = v_s3;
		end else if (upd_s4 && gate_s4 == gate_s2 && slot_s4 == slot_s2) begin
			ring_f = v_s4;
		end else if (tag_s2.iq) begin
			ring_f = $signed({1'b0, rring_s2});
		end else begin
			ring_f = $signed({rring_s2[RING_W-1], rring_s2});
		end
		new_sum = sum_f + SUM_W'(v) - SUM_W'(ring_f);
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			sum_mem[clr_cnt_q[GATE_W-1:0]] <= '0;
			ring_mem[clr_cnt_q]            <= '0;
		end else if (en && upd_s2) begin
			sum_mem[gate_s2]           <= new_sum;
			ring_mem[{slot_s2, gate_s2}] <= v[RING_W-1:0];
		end
	end

	assign clearing = clearing_q;
	assign sum      = sum_s3;
	assign tag_o    = tag_s3;

endmodule
`default_nettype wire

### rtl/npi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npi_div
// Rounded division of the window sum by the window length, six bits a stage.
// ----------------------------------------------------------------------------
module npi_div import npi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic signed [SUM_W-1:0] sum,
	input  logic [N_W-1:0]          n,
	input  npi_tag_t                tag,
	output logic [MAG_W-1:0]        q,
	output logic                    neg,
	output npi_tag_t                tag_o
);

	logic signed [SUM_W-1:0] t_sa;
	npi_tag_t                tag_sa;
	logic [MAG_W-1:0]        dq_s   [DIV_STAGES+1];
	logic [N_W-1:0]          rm_s   [DIV_STAGES+1];
	logic                    neg_s  [DIV_STAGES+1];
	npi_tag_t                tag_s  [DIV_STAGES+1];
	logic [MAG_W-1:0]        dq_nx  [DIV_STAGES];
	logic [N_W-1:0]          rm_nx  [DIV_STAGES];

	// Restoring division; the remainder always stays below n.
	always_comb begin
		logic [MAG_W-1:0] d;
		logic [N_W-1:0]   r;
		logic [N_W:0]     tr;
		for (int k = 0; k < DIV_STAGES; k++) begin
			d = dq_s[k];
			r = rm_s[k];
			for (int j = 0; j < DIV_STEP; j++) begin
				tr = {r, d[MAG_W-1]};
				d = {d[MAG_W-2:0], 1'b0};
				if (tr >= {1'b0, n}) begin
					tr = tr - {1'b0, n};
					d[0] = 1'b1;
				end
				r = tr[N_W-1:0];
			end
			dq_nx[k] = d;
			rm_nx[k] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_sa <= '0;
			for (int k = 0; k <= DIV_STAGES; k++) begin
				tag_s[k] <= '0;
			end
		end else if (en) begin
			tag_sa   <= tag;
			tag_s[0] <= tag_sa;
			for (int k = 0; k < DIV_STAGES; k++) begin
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_sa     <= sum + $signed(SUM_W'(n >> 1));
			neg_s[0] <= t_sa[SUM_W-1];
			dq_s[0]  <= MAG_W'(t_sa[SUM_W-1] ? -t_sa : t_sa);
			rm_s[0]  <= '0;
			for (int k = 0; k < DIV_STAGES; k++) begin
				dq_s[k+1]  <= dq_nx[k];
				rm_s[k+1]  <= rm_nx[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign q     = dq_s[DIV_STAGES];
	assign neg   = neg_s[DIV_STAGES];
	assign tag_o = tag_s[DIV_STAGES];

endmodule
`default_nettype wire

### rtl/npi_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npi_isqrt
// Digit-by-digit integer square root, four result bits a stage.
// ----------------------------------------------------------------------------
module npi_isqrt import npi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [MAG_W-1:0]  q,
	input  logic              neg,
	input  npi_tag_t          tag,
	output logic [ROOT_W-1:0] root,
	output logic [REM_W-1:0]  rem,
	output logic [VAL_W-1:0]  raw,
	output npi_tag_t          tag_o
);

	logic [X_W-1:0]    x_s    [SQ_STAGES+1];
	logic [REM_W-1:0]  rem_s  [SQ_STAGES+1];
	logic [ROOT_W-1:0] root_s [SQ_STAGES+1];
	logic [VAL_W-1:0]  raw_s  [SQ_STAGES+1];
	npi_tag_t          tag_s  [SQ_STAGES+1];
	logic [X_W-1:0]    x_nx    [SQ_STAGES];
	logic [REM_W-1:0]  rem_nx  [SQ_STAGES];
	logic [ROOT_W-1:0] root_nx [SQ_STAGES];

	always_comb begin
		logic [X_W-1:0]    x;
		logic [REM_W-1:0]  r;
		logic [ROOT_W-1:0] rt;
		logic [REM_W-1:0]  trial;
		for (int k = 0; k < SQ_STAGES; k++) begin
			x  = x_s[k];
			r  = rem_s[k];
			rt = root_s[k];
			for (int j = 0; j < SQ_STEP; j++) begin
				r = {r[REM_W-3:0], x[X_W-1:X_W-2]};
				x = {x[X_W-3:0], 2'b00};
				trial = REM_W'({rt, 2'b01});
				if (r >= trial) begin
					r  = r - trial;
					rt = {rt[ROOT_W-2:0], 1'b1};
				end else begin
					rt = {rt[ROOT_W-2:0], 1'b0};
				end
			end
			x_nx[k]    = x;
			rem_nx[k]  = r;
			root_nx[k] = rt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQ_STAGES; k++) begin
				tag_s[k] <= '0;
			end
		end else if (en) begin
			tag_s[0] <= tag;
			for (int k = 0; k < SQ_STAGES; k++) begin
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= q[X_W-1:0];
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			raw_s[0]  <= neg ? -q[VAL_W-1:0] : q[VAL_W-1:0];
			for (int k = 0; k < SQ_STAGES; k++) begin
				x_s[k+1]    <= x_nx[k];
				rem_s[k+1]  <= rem_nx[k];
				root_s[k+1] <= root_nx[k];
				raw_s[k+1]  <= raw_s[k];
			end
		end
	end

	assign root  = root_s[SQ_STAGES];
	assign rem   = rem_s[SQ_STAGES];
	assign raw   = raw_s[SQ_STAGES];
	assign tag_o = tag_s[SQ_STAGES];

endmodule
`default_nettype wire

### test/noncoherent_pulse_integrator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// noncoherent_pulse_integrator_test
// Self-checking bench for the sliding-window pulse integrator.
// ----------------------------------------------------------------------------
// Range-gate samples are driven in phases, each under one register setting.
// A scoreboard class tracks the per-gate window sums and history ring, predicts
// every result and compares it in order with what leaves the block. Both
// channels idle at random, apart from one phase that runs at full rate.
// ----------------------------------------------------------------------------
module noncoherent_pulse_integrator_test;
	import npi_pkg::*;

	localparam cfg_reg_t REG_UNUSED = cfg_reg_t'(2'd3);
	localparam int DRAIN_CYCLES = 24;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic signed [SMP_W-1:0] bypass_q;
		logic                    last_gate;
	} gate_result_t;

	class npi_scoreboard;
		longint      gate_sum[GATES];
		longint      ring[MAX_PULSES][GATES];
		int unsigned pulses_done;
		int unsigned row;
		int unsigned gate_pos;
		bit          en;
		logic [4:0]  np;
		bit          iq;
		gate_result_t awaited[$];
		int errors;
		int matched;
		int accepted;

		function new();
			en = 1'b1;
			np = 5'd4;
			iq = 1'b0;
			clear_window();
			errors = 0;
			matched = 0;
			accepted = 0;
		endfunction

		function void clear_window();
			foreach (gate_sum[g]) gate_sum[g] = 0;
			foreach (ring[s, g]) ring[s][g] = 0;
			pulses_done = 0;
			row = 0;
			gate_pos = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ENABLED: begin
					en = data[0];
				end
				REG_NUM_PULSES: begin
					np = data;
					clear_window();
				end
				REG_IQ_MODE: begin
					iq = data[0];
					clear_window();
				end
				default: begin
				end
			endcase
		endfunction

		// Integer square root, rounded to nearest.
		function longint root_nearest(longint x);
			longint lo, hi, mid;
			lo = 0;
			hi = 1 << 20;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				if (mid * mid <= x) lo = mid;
				else hi = mid - 1;
			end
			return (x - lo * lo > lo) ? lo + 1 : lo;
		endfunction

		function void note_sample(logic signed [SMP_W-1:0] si, logic signed [SMP_W-1:0] sq,
				logic last);
			int unsigned n, g, s;
			longint v, q;
			gate_result_t r;
			n = (np == 0) ? 1 : ((np > MAX_PULSES) ? MAX_PULSES : np);
			g = gate_pos;
			accepted++;
			if (gate_pos < GATES) gate_pos++;
			if (!en || n == 1) begin
				r.value = VAL_W'(si);
				r.bypass_q = iq ? sq : '0;
				r.last_gate = last;
				awaited = {awaited, r};
				if (last) gate_pos = 0;
				return;
			end
			if (g < GATES) begin
				s = row % n;
				v = iq ? longint'(si) * si + longint'(sq) * sq : longint'(si);
				gate_sum[g] += v - ring[s][g];
				ring[s][g] = v;
				if (pulses_done + 1 >= n) begin
					q = (gate_sum[g] + longint'(n / 2)) / longint'(n);
					if (iq) q = root_nearest(q < 0 ? 0 : q);
					r.value = q[VAL_W-1:0];
					r.bypass_q = '0;
					r.last_gate = last;
					awaited = {awaited, r};
				end
			end
			if (last) begin
				gate_pos = 0;
				row = (row + 1) % n;
				if (pulses_done < n) pulses_done++;
			end
		endfunction

		function void check_result(logic signed [VAL_W-1:0] value,
				logic signed [SMP_W-1:0] bq, logic last);
			gate_result_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result value=%0d bypass_q=%0d last_gate=%0b",
					$time, value, bq, last);
				errors++;
				return;
			end
			e = awaited.pop_front();
			matched++;
			if (value !== e.value) begin
				$display("%0t: value expected %0d, got %0d", $time, e.value, value);
				errors++;
			end
			if (bq !== e.bypass_q) begin
				$display("%0t: bypass_q expected %0d, got %0d", $time, e.bypass_q, bq);
				errors++;
			end
			if (last !== e.last_gate) begin
				$display("%0t: last_gate expected %0b, got %0b", $time, e.last_gate, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	npi_scoreboard sb;

	npi_in_if  din();
	npi_out_if dout();
	npi_cfg_if cfg();

	noncoherent_pulse_integrator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din.sink),
		.dout   (dout.source),
		.cfg    (cfg.sink)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < 30);
	endfunction

	function automatic logic signed [SMP_W-1:0] pick_sample();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k == 0) return 16'sh8000;
		if (k == 1) return 16'sh7fff;
		if (k == 2) return SMP_W'($urandom_range(0, 15)) - 16'sd8;
		return SMP_W'($urandom);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
		end else begin
			dout.ready <= !take_break();
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready)
			sb.check_result(dout.value, dout.bypass_q, dout.last_gate);
	end

	task automatic send_gate(logic signed [SMP_W-1:0] si, logic signed [SMP_W-1:0] sq,
			logic last);
		while (take_break()) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.sample_i <= si;
		din.sample_q <= sq;
		din.pulse_end <= last;
		do @(posedge clk); while (!din.ready);
		sb.note_sample(si, sq, last);
	endtask

	task automatic send_pulse(int unsigned gates);
		for (int unsigned g = 0; g < gates; g++)
			send_gate(pick_sample(), pick_sample(), g == gates - 1);
	endtask

	// Pulses mostly of one length so that windows fill, with some of random length.
	task automatic random_pulses(int unsigned items);
		int unsigned sent, len, base;
		sent = 0;
		base = $urandom_range(2, 6);
		while (sent < items) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, base + 2) : base;
			send_pulse(len);
			sent += len;
		end
	endtask

	task automatic settle();
		din.valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, data);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(bit en, logic [CFG_DATA_W-1:0] np, bit iq);
		settle();
		write_reg(REG_ENABLED, CFG_DATA_W'(en));
		write_reg(REG_NUM_PULSES, np);
		write_reg(REG_IQ_MODE, CFG_DATA_W'(iq));
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
	endtask

	initial begin
		#15_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		calm = 1'b0;
		din.valid = 1'b0;
		din.sample_i = '0;
		din.sample_q = '0;
		din.pulse_end = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_ENABLED;
		cfg.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting: four pulses, raw mode, with the sample extremes.
		for (int p = 0; p < 5; p++) begin
			send_gate(16'sh8000, 16'sh7fff, 1'b0);
			send_gate(16'sh7fff, 16'sh8000, 1'b0);
			send_gate(p[0] ? 16'sh8000 : 16'sh7fff, '0, 1'b0);
			send_gate(16'sd0, 16'sh7fff, 1'b1);
		end
		send_gate(16'sd3, '0, 1'b1);

		calm = 1'b1;
		setup(1'b1, 5'd16, 1'b0);
		random_pulses(70);
		calm = 1'b0;

		setup(1'b1, 5'd31, 1'b1);
		random_pulses(60);
		// Toggling enabled leaves the window as it is.
		settle();
		write_reg(REG_ENABLED, CFG_DATA_W'(0));
		random_pulses(20);
		settle();
		write_reg(REG_ENABLED, CFG_DATA_W'(1));
		random_pulses(40);

		setup(1'b1, 5'd0, 1'b0);
		random_pulses(30);
		setup(1'b1, 5'd1, 1'b1);
		random_pulses(30);
		setup(1'b0, 5'd2, 1'b1);
		random_pulses(30);

		setup(1'b1, 5'd3, 1'b1);
		random_pulses(90);
		setup(1'b1, 5'd5, 1'b0);
		random_pulses(90);
		setup(1'b1, 5'd2, 1'b1);
		for (int k = 0; k < 6; k++) begin
			send_gate(16'sh8000, 16'sh8000, 1'b0);
			send_gate(16'sh7fff, 16'sh8000, 1'b1);
		end
		random_pulses(60);

		settle();
		$display("Drove %0d range-gate requests over raw, IQ, bypass and disabled settings.",
			sb.accepted);
		$display("Checked %0d results against the window predictor, %0d mismatches.",
			sb.matched, sb.errors);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
